// File: hw/rtl/ptc_pkg.sv
// Shared types and constants for the pressure/temperature compensation block.
`timescale 1ns / 1ps
`default_nettype none
package ptc_pkg;

    localparam logic [2:0] REG_A1 = 3'd0;
    localparam logic [2:0] REG_A2 = 3'd1;
    localparam logic [2:0] REG_A3 = 3'd2;
    localparam logic [2:0] REG_A4 = 3'd3;
    localparam logic [2:0] REG_A5 = 3'd4;
    localparam logic [2:0] REG_A6 = 3'd5;
    localparam logic [2:0] REG_BP = 3'd6;
    localparam logic [2:0] REG_MP = 3'd7;

    localparam logic OP_TEMP  = 1'b0;
    localparam logic OP_PRESS = 1'b1;

    localparam logic signed [31:0] B6_OFFSET = 32'sd4000;
    localparam logic [31:0]        B4_BIAS   = 32'd32768;
    localparam logic [31:0]        B7_SCALE  = 32'd50000;
    localparam logic [31:0]        MSB_MARK  = 32'h8000_0000;
    localparam logic signed [31:0] K_SQ      = 32'sd3038;
    localparam logic signed [31:0] K_LIN     = -32'sd7357;
    localparam logic signed [31:0] K_OFS     = 32'sd3791;

    // Datapath steps, issued one per cycle (divides wait on the divider, the result step on the output stall).
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_T_X1A, ST_T_X1B, ST_T_DEN, ST_T_DIV, ST_T_WAIT, ST_T_FIN,
        ST_P_B6, ST_P_SQ, ST_P_X1, ST_P_X2, ST_P_B3, ST_P_Y1, ST_P_Y2,
        ST_P_X3, ST_P_B4, ST_P_B7, ST_P_DIV, ST_P_WAIT, ST_P_PU,
        ST_P_Q1, ST_P_Q2, ST_P_Q3, ST_P_Q4, ST_P_FIN,
        ST_OUT
    } t_state;

    typedef struct packed {
        t_state step;
        logic   load;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic div_zero;
    } t_status;

endpackage
`default_nettype wire

// File: hw/rtl/ptc_div.sv
// Unsigned 32-bit restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ptc_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_num,
    input  wire logic [31:0] i_den,
    output logic             o_busy,
    output logic [31:0]      o_quot
);
    logic [31:0] r_quot, n_quot;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt, n_cnt;
    logic [32:0] trial;

    always_comb begin
        trial  = {r_rem, r_quot[31]} - {1'b0, r_den};
        n_rem  = r_rem;
        n_quot = r_quot;
        n_cnt  = r_cnt;
        if (r_cnt != 6'd0) begin
            if (!trial[32]) begin
                n_rem = trial[31:0];
            end else begin
                n_rem = {r_rem[30:0], r_quot[31]};
            end
            n_quot = {r_quot[30:0], ~trial[32]};
            n_cnt  = r_cnt - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 6'd0;
        end else if (i_start) begin
            r_cnt <= 6'd32;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= 32'd0;
            r_den  <= i_den;
        end else begin
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end
    end

    assign o_busy = (r_cnt != 6'd0);
    assign o_quot = r_quot;
endmodule
`default_nettype wire

// File: hw/rtl/ptc_datapath.sv
// Compensation datapath: calibration registers, work registers, multiplier, divider.
`timescale 1ns / 1ps
`default_nettype none
module ptc_datapath (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire ptc_pkg::t_cmd   i_cmd,
    output ptc_pkg::t_status     o_status,
    input  wire logic            i_cfg_we,
    input  wire logic [2:0]      i_cfg_index,
    input  wire logic [31:0]     i_cfg_data,
    input  wire logic            i_opcode,
    input  wire logic [23:0]     i_raw_word,
    input  wire logic [1:0]      i_oversampling,
    output logic                 o_result_kind,
    output logic signed [31:0]   o_compensated_value,
    output logic                 o_div_error
);
    import ptc_pkg::*;

    logic signed [15:0] r_a1, r_a2, r_a3, r_b1, r_b2, r_mc, r_md;
    logic [15:0]        r_a4, r_a5, r_a6;
    logic signed [31:0] r_b5;
    logic               r_kind;
    logic [23:0]        r_raw;
    logic [1:0]         r_oss;
    logic signed [31:0] r_b6, r_sq, r_x1, r_x2, r_b3, r_acc, r_p;
    logic [31:0]        r_b4, r_b7;
    logic signed [31:0] r_val;
    logic               r_err;

    logic signed [31:0] mul_a, mul_b, mul_p;
    logic [31:0]        div_num, div_den, div_q;
    logic               div_start, div_busy;
    logic signed [31:0] ut, up, den_t, mc_n, sum_t;
    logic signed [31:0] q_mag;
    logic               neg_q;

    ptc_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (div_den),
        .o_busy (div_busy),
        .o_quot (div_q)
    );

    // One shared 32x32 wrap multiply, operands chosen by step.
    assign mul_p = mul_a * mul_b;
    assign ut    = {16'd0, r_raw[15:0]};
    assign up    = {8'd0, r_raw >> (4'd8 - {2'd0, r_oss})};
    assign den_t = r_x1 + 32'(r_md);
    assign mc_n  = 32'(r_mc) <<< 11;
    assign neg_q = mc_n[31] ^ den_t[31];
    assign q_mag = neg_q ? -div_q : div_q;
    assign sum_t = 32'(r_a1) * 32'sd4 + r_acc;

    always_comb begin
        mul_a = r_b6;
        mul_b = r_b6;
        case (i_cmd.step)
            ST_T_X1A: begin mul_a = ut - 32'($signed({1'b0, r_a6})); mul_b = 32'(r_a5); end
            ST_P_SQ:  begin mul_a = r_b6; mul_b = r_b6; end
            ST_P_X1:  begin mul_a = 32'(r_b2); mul_b = r_sq; end
            ST_P_X2:  begin mul_a = 32'(r_a2); mul_b = r_b6; end
            ST_P_Y1:  begin mul_a = 32'(r_a3); mul_b = r_b6; end
            ST_P_Y2:  begin mul_a = 32'(r_b1); mul_b = r_sq; end
            ST_P_B4:  begin mul_a = 32'(r_a4); mul_b = r_acc + B4_BIAS; end
            ST_P_B7:  begin mul_a = up - r_b3; mul_b = B7_SCALE >> r_oss; end
            ST_P_Q1:  begin mul_a = r_p >>> 8; mul_b = r_p >>> 8; end
            ST_P_Q2:  begin mul_a = r_x1; mul_b = K_SQ; end
            ST_P_Q3:  begin mul_a = K_LIN; mul_b = r_p; end
            default:  begin mul_a = r_b6; mul_b = r_b6; end
        endcase
    end

    always_comb begin
        div_start = 1'b0;
        div_num   = 32'd0;
        div_den   = 32'd0;
        case (i_cmd.step)
            ST_T_DIV: begin
                div_start = (den_t != 32'sd0);
                div_num   = mc_n[31] ? -mc_n : mc_n;
                div_den   = den_t[31] ? -den_t : den_t;
            end
            ST_P_DIV: begin
                div_start = (r_b4 != 32'd0);
                div_num   = (r_b7 < MSB_MARK) ? (r_b7 << 1) : r_b7;
                div_den   = r_b4;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a1 <= '0; r_a2 <= '0; r_a3 <= '0; r_a4 <= '0; r_a5 <= '0; r_a6 <= '0;
            r_b1 <= '0; r_b2 <= '0; r_mc <= '0; r_md <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_A1: r_a1 <= i_cfg_data[15:0];
                REG_A2: r_a2 <= i_cfg_data[15:0];
                REG_A3: r_a3 <= i_cfg_data[15:0];
                REG_A4: r_a4 <= i_cfg_data[15:0];
                REG_A5: r_a5 <= i_cfg_data[15:0];
                REG_A6: r_a6 <= i_cfg_data[15:0];
                REG_BP: begin r_b1 <= i_cfg_data[31:16]; r_b2 <= i_cfg_data[15:0]; end
                REG_MP: begin r_mc <= i_cfg_data[31:16]; r_md <= i_cfg_data[15:0]; end
                default: r_a1 <= r_a1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b5 <= 32'sd0;
        end else if (i_cmd.step == ST_T_FIN) begin
            r_b5 <= r_x1 + q_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_opcode;
            r_raw  <= i_raw_word;
            r_oss  <= i_oversampling;
            r_err  <= 1'b0;
        end
        case (i_cmd.step)
            ST_T_X1A: r_x1 <= mul_p >>> 15;
            ST_T_DEN: if (den_t == 32'sd0) begin r_err <= 1'b1; r_val <= 32'sd0; end
            ST_T_FIN: r_val <= (r_x1 + q_mag + 32'sd8) >>> 4;
            ST_P_B6:  r_b6 <= r_b5 - B6_OFFSET;
            ST_P_SQ:  r_sq <= mul_p >>> 12;
            ST_P_X1:  r_x1 <= mul_p >>> 11;
            ST_P_X2:  r_acc <= r_x1 + (mul_p >>> 11);
            ST_P_B3:  r_b3 <= ((sum_t <<< r_oss) + 32'sd2) / 4;
            ST_P_Y1:  r_x1 <= mul_p >>> 13;
            ST_P_Y2:  r_x2 <= mul_p >>> 16;
            ST_P_X3:  r_acc <= (r_x1 + r_x2 + 32'sd2) >>> 2;
            ST_P_B4:  r_b4 <= 32'($unsigned(mul_p)) >> 15;
            ST_P_B7:  r_b7 <= mul_p;
            ST_P_DIV: if (r_b4 == 32'd0) begin r_err <= 1'b1; r_val <= 32'sd0; end
            ST_P_PU:  r_p <= (r_b7 < MSB_MARK) ? div_q : (div_q << 1);
            ST_P_Q1:  r_x1 <= mul_p;
            ST_P_Q2:  r_x1 <= mul_p >>> 16;
            ST_P_Q3:  r_x2 <= mul_p >>> 16;
            ST_P_Q4:  r_acc <= (r_x1 + r_x2 + K_OFS) >>> 4;
            ST_P_FIN: r_val <= r_p + r_acc;
            default:  r_b7 <= r_b7;
        endcase
    end

    assign o_status.div_busy = div_busy;
    assign o_status.div_zero = r_err;
    assign o_result_kind       = r_kind;
    assign o_compensated_value = r_val;
    assign o_div_error         = r_err;
endmodule
`default_nettype wire

// File: hw/rtl/ptc_ctrl.sv
// Step sequencer for the compensation datapath and the handshake on both sides.
`timescale 1ns / 1ps
`default_nettype none
module ptc_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic           i_opcode,
    output logic                o_stall,
    output logic                o_valid,
    input  wire logic           i_stall,
    output ptc_pkg::t_cmd       o_cmd,
    input  wire ptc_pkg::t_status i_status
);
    import ptc_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.step = r_state;
        o_cmd.load = 1'b0;
        o_stall    = 1'b1;
        o_valid    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.load = i_valid;
                if (i_valid) begin
                    n_state = (i_opcode == OP_TEMP) ? ST_T_X1A : ST_P_B6;
                end
            end
            ST_T_X1A:  n_state = ST_T_X1B;
            ST_T_X1B:  n_state = ST_T_DEN;
            ST_T_DEN:  n_state = ST_T_DIV;
            ST_T_DIV:  n_state = i_status.div_zero ? ST_OUT : ST_T_WAIT;
            ST_T_WAIT: if (!i_status.div_busy) begin n_state = ST_T_FIN; end
            ST_T_FIN:  n_state = ST_OUT;
            ST_P_B6:   n_state = ST_P_SQ;
            ST_P_SQ:   n_state = ST_P_X1;
            ST_P_X1:   n_state = ST_P_X2;
            ST_P_X2:   n_state = ST_P_B3;
            ST_P_B3:   n_state = ST_P_Y1;
            ST_P_Y1:   n_state = ST_P_Y2;
            ST_P_Y2:   n_state = ST_P_X3;
            ST_P_X3:   n_state = ST_P_B4;
            ST_P_B4:   n_state = ST_P_B7;
            ST_P_B7:   n_state = ST_P_DIV;
            ST_P_DIV:  n_state = ST_P_WAIT;
            ST_P_WAIT: begin
                if (i_status.div_zero) begin
                    n_state = ST_OUT;
                end else if (!i_status.div_busy) begin
                    n_state = ST_P_PU;
                end
            end
            ST_P_PU:   n_state = ST_P_Q1;
            ST_P_Q1:   n_state = ST_P_Q2;
            ST_P_Q2:   n_state = ST_P_Q3;
            ST_P_Q3:   n_state = ST_P_Q4;
            ST_P_Q4:   n_state = ST_P_FIN;
            ST_P_FIN:  n_state = ST_OUT;
            ST_OUT: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// File: hw/rtl/pressure_temperature_compensation.sv
// Top level of the barometric pressure and temperature compensation block.
`timescale 1ns / 1ps
`default_nettype none
// One reading is taken at a time. A temperature word and a pressure word each run one 32-bit
// unsigned division at one quotient bit per cycle, unless the divisor is zero. Pressure uses
// the intermediate term left by the last good temperature word (zero after reset). The user
// must write calibration through the config port only while no word is in flight; the block
// itself does not enforce this.
module pressure_temperature_compensation (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_opcode,
    input  wire logic [23:0]        i_raw_word,
    input  wire logic [1:0]         i_oversampling,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_result_kind,
    output logic signed [31:0]      o_compensated_value,
    output logic                    o_div_error,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);
    import ptc_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    ptc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_opcode(i_opcode),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd),
        .i_status(status)
    );

    ptc_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_cfg_we           (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_opcode           (i_opcode),
        .i_raw_word         (i_raw_word),
        .i_oversampling     (i_oversampling),
        .o_result_kind      (o_result_kind),
        .o_compensated_value(o_compensated_value),
        .o_div_error        (o_div_error)
    );

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_div_error) |-> (o_compensated_value == 32'sd0))
        else $error("division error with nonzero value");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while result pending");
    a_div_idle_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !status.div_busy)
        else $error("result shown while divider running");
endmodule
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the pressure/temperature compensation block.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import ptc_pkg::*;

    typedef struct packed {
        logic        op;
        logic [23:0] raw;
        logic [1:0]  oss;
    } sample_t;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] val;
        logic               err;
    } reading_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_opcode = OP_TEMP;
    logic [23:0]        i_raw_word = '0;
    logic [1:0]         i_oversampling = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic               o_result_kind;
    logic signed [31:0] o_compensated_value;
    logic               o_div_error;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = REG_A1;
    logic [31:0]        i_cfg_data = '0;

    pressure_temperature_compensation dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Calibration and the held B5 term, as the block should see them
    logic [15:0]        cal_a1 = '0, cal_a2 = '0, cal_a3 = '0;
    logic [15:0]        cal_a4 = '0, cal_a5 = '0, cal_a6 = '0;
    logic [31:0]        cal_bp = '0, cal_mp = '0;
    logic signed [31:0] b5_held = '0;

    sample_t  pending_words[$];
    reading_t expected_readings[$];
    int       in_flight = 0;
    int       err_count = 0;
    bit       quiet = 1'b0;

    function automatic logic signed [31:0] sx16(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic int pause_len();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Compensate one reading; a good temperature word updates the held B5
    function automatic reading_t compensate(sample_t s);
        logic signed [31:0] ut, mc, md, x1, x2, x3, den, b5, up, b6, sq, b3, p, t;
        logic [31:0]        b4, b7, pu;
        reading_t           r;
        r.kind = s.op;
        r.val  = '0;
        r.err  = 1'b0;
        if (s.op == OP_TEMP) begin
            ut  = {16'b0, s.raw[15:0]};
            mc  = sx16(cal_mp[31:16]);
            md  = sx16(cal_mp[15:0]);
            t   = (ut - $signed({16'b0, cal_a6})) * $signed({16'b0, cal_a5});
            x1  = t >>> 15;
            den = x1 + md;
            if (den == 0) begin
                r.err = 1'b1;
            end else begin
                t       = mc * 32'sd2048;
                x2      = t / den;
                b5      = x1 + x2;
                b5_held = b5;
                t       = b5 + 32'sd8;
                r.val   = t >>> 4;
            end
        end else begin
            up = $signed({8'b0, s.raw} >> (4'd8 - {2'b0, s.oss}));
            b6 = b5_held - B6_OFFSET;
            t  = b6 * b6;
            sq = t >>> 12;
            t  = sx16(cal_bp[15:0]) * sq;
            x1 = t >>> 11;
            t  = sx16(cal_a2) * b6;
            x2 = t >>> 11;
            x3 = x1 + x2;
            t  = (sx16(cal_a1) * 32'sd4 + x3) << s.oss;
            t  = t + 32'sd2;
            b3 = t / 32'sd4;
            t  = sx16(cal_a3) * b6;
            x1 = t >>> 13;
            t  = sx16(cal_bp[31:16]) * sq;
            x2 = t >>> 16;
            t  = x1 + x2 + 32'sd2;
            x3 = t >>> 2;
            b4 = ({16'b0, cal_a4} * ($unsigned(x3) + B4_BIAS)) >> 15;
            b7 = ($unsigned(up) - $unsigned(b3)) * (B7_SCALE >> s.oss);
            if (b4 == 0) begin
                r.err = 1'b1;
            end else begin
                if (b7 < MSB_MARK) pu = (b7 * 32'd2) / b4;
                else pu = (b7 / b4) * 32'd2;
                p  = $signed(pu);
                t  = p >>> 8;
                x1 = t * t;
                t  = x1 * K_SQ;
                x1 = t >>> 16;
                t  = K_LIN * p;
                x2 = t >>> 16;
                t  = x1 + x2 + K_OFS;
                p  = p + (t >>> 4);
                r.val = p;
            end
        end
        return r;
    endfunction

    // Driver
    sample_t cur;
    int      send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_readings.push_back(compensate(cur));
                send_gap = pause_len();
            end
            if (i_valid && o_stall) begin
                // hold the stalled word
            end else if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                cur = pending_words.pop_front();
                i_opcode       <= cur.op;
                i_raw_word     <= cur.raw;
                i_oversampling <= cur.oss;
                i_valid        <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor
    int       stall_left = 0;
    reading_t want;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_readings.size() == 0) begin
                $error("unexpected result: kind %0d value %0d", o_result_kind,
                       o_compensated_value);
                err_count++;
            end else begin
                want = expected_readings.pop_front();
                in_flight--;
                if (o_result_kind !== want.kind) begin
                    $error("result_kind: expected %0d, got %0d", want.kind, o_result_kind);
                    err_count++;
                end
                if (o_compensated_value !== want.val) begin
                    $error("compensated_value: expected %0d, got %0d", want.val,
                           o_compensated_value);
                    err_count++;
                end
                if (o_div_error !== want.err) begin
                    $error("div_error: expected %0d, got %0d", want.err, o_div_error);
                    err_count++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            stall_left = ($urandom_range(0, 3) == 0) ? pause_len() : 0;
            i_stall <= (stall_left > 0);
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_A1: cal_a1 = data[15:0];
            REG_A2: cal_a2 = data[15:0];
            REG_A3: cal_a3 = data[15:0];
            REG_A4: cal_a4 = data[15:0];
            REG_A5: cal_a5 = data[15:0];
            REG_A6: cal_a6 = data[15:0];
            REG_BP: cal_bp = data;
            REG_MP: cal_mp = data;
            default: ;
        endcase
    endtask

    // Upper bits of the 16-bit registers are junk and must be dropped
    task automatic load_cal(logic [15:0] a1, a2, a3, a4, a5, a6, logic [31:0] bp, mp);
        write_reg(REG_A1, {16'($urandom), a1});
        write_reg(REG_A2, {16'($urandom), a2});
        write_reg(REG_A3, {16'($urandom), a3});
        write_reg(REG_A4, {16'($urandom), a4});
        write_reg(REG_A5, {16'($urandom), a5});
        write_reg(REG_A6, {16'($urandom), a6});
        write_reg(REG_BP, bp);
        write_reg(REG_MP, mp);
    endtask

    task automatic send(logic op, logic [23:0] raw, logic [1:0] oss);
        sample_t s;
        s.op  = op;
        s.raw = raw;
        s.oss = oss;
        in_flight++;
        pending_words.push_back(s);
    endtask

    task automatic drain();
        do @(posedge i_clk); while (in_flight != 0);
        repeat (60) @(posedge i_clk);
    endtask

    // Mostly a temperature word followed by a few pressure words; some noise
    task automatic random_burst(int n);
        int k;
        int j;
        k = 0;
        while (k < n) begin
            if ($urandom_range(0, 99) < 85) begin
                send(OP_TEMP, 24'($urandom), 2'($urandom));
                k++;
                for (j = $urandom_range(1, 3); j > 0; j--) begin
                    send(OP_PRESS, 24'($urandom), 2'($urandom));
                    k++;
                end
            end else begin
                send(1'($urandom), 24'($urandom), 2'($urandom));
                k++;
            end
        end
    endtask

    initial begin
        int ph;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset calibration: pressure before any temperature, both divisors zero
        send(OP_PRESS, 24'hFFFFFF, 2'd3);
        send(OP_TEMP, 24'h000000, 2'd0);
        send(OP_PRESS, 24'h000000, 2'd0);
        drain();

        // Typical calibration
        load_cal(16'd408, -16'sd72, -16'sd14383, 16'd32741, 16'd32757, 16'd23153,
                 {16'd6190, 16'd4}, {-16'sd8711, 16'd2868});
        send(OP_TEMP, 24'd27898, 2'd0);
        send(OP_PRESS, 24'd23843 << 8, 2'd0);
        send(OP_PRESS, 24'h5D2300, 2'd1);
        send(OP_PRESS, 24'hA1B2C3, 2'd2);
        send(OP_PRESS, 24'hFFFFFF, 2'd3);
        send(OP_PRESS, 24'h000000, 2'd3);
        send(OP_TEMP, 24'hFF6CFA, 2'd3);
        send(OP_TEMP, 24'h000000, 2'd1);
        send(OP_TEMP, 24'h00FFFF, 2'd2);
        send(OP_PRESS, 24'h800000, 2'd0);
        send(OP_TEMP, 24'd27898, 2'd0);
        send(OP_PRESS, 24'h7FFFFF, 2'd1);
        drain();

        // Zero temperature divisor keeps the old B5; zero pressure divisor
        load_cal(16'd408, -16'sd72, -16'sd14383, 16'd0, 16'd0, 16'd23153,
                 {16'd6190, 16'd4}, {-16'sd8711, 16'd0});
        send(OP_TEMP, 24'd27898, 2'd0);
        send(OP_PRESS, 24'h5D2300, 2'd0);
        drain();

        for (ph = 0; ph < 8; ph++) begin
            quiet = (ph == 2);
            case (ph)
                0: load_cal(16'd408, -16'sd72, -16'sd14383, 16'd32741, 16'd32757,
                            16'd23153, {16'd6190, 16'd4}, {-16'sd8711, 16'd2868});
                1: load_cal(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                            32'h7FFF7FFF, 32'h7FFF7FFF);
                2: load_cal(16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000,
                            32'h80008000, 32'h80008000);
                3: load_cal(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                            16'd0, 16'($urandom), $urandom, {16'($urandom), 16'd0});
                default: load_cal(16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom), 16'($urandom), 16'($urandom),
                                  $urandom, $urandom);
            endcase
            random_burst(250);
            drain();
        end

        if (err_count == 0) $display("testbench: clean");
        else $display("testbench: errors");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("testbench: errors");
        $finish;
    end
endmodule
`default_nettype wire
